@@ rtl/sdspi_pkg.sv @@
`default_nettype none
package sdspi_pkg;

  // Input operation codes (carried on in_tuser)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RX    = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_READY_TIMEOUT = 1'b0;
  localparam logic CFG_POLL_LIMIT    = 1'b1;

  localparam logic [15:0] READY_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd10;

  // Command indexes with special handling
  localparam logic [6:0] IDX_GO_IDLE = 7'd0;
  localparam logic [6:0] IDX_IF_COND = 7'd8;
  localparam logic [6:0] IDX_STOP    = 7'd12;
  localparam logic [6:0] IDX_APP     = 7'd55;

  localparam logic [7:0] START_BITS   = 8'h40;
  localparam logic [7:0] CRC_GO_IDLE  = 8'h95;
  localparam logic [7:0] CRC_IF_COND  = 8'h87;
  localparam logic [7:0] CRC_DEFAULT  = 8'h01;
  localparam logic [7:0] DUMMY_BYTE   = 8'hFF;
  localparam logic [7:0] TOUT_RESP    = 8'hFF;
  localparam logic [7:0] APP_RESP_MAX = 8'h01;
  localparam logic [2:0] FRAME_LAST   = 3'd5;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_DESEL = 8'b0000_0010,
    PH_SEL   = 8'b0000_0100,
    PH_READY = 8'b0000_1000,
    PH_FRAME = 8'b0001_0000,
    PH_SKIP  = 8'b0010_0000,
    PH_RESP  = 8'b0100_0000,
    PH_TOUT  = 8'b1000_0000
  } phase_t;

  // One result; tx_valid ends up in the lowest bit
  typedef struct packed {
    logic       busy_res;
    logic [7:0] response;
    logic       done_res;
    logic       chip_select_low;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic [7:0] frame_byte(input logic [6:0] idx, input logic [31:0] arg,
                                            input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = START_BITS | {1'b0, idx};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (idx == IDX_GO_IDLE) b = CRC_GO_IDLE;
        else if (idx == IDX_IF_COND) b = CRC_IF_COND;
        else b = CRC_DEFAULT;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sd_spi_command_sequencer.sv @@
`default_nettype none
// SD card SPI-mode command sequencer, host side. Each input transaction is a start
// request, the byte received from the last requested SPI exchange, or a millisecond
// tick; each one yields exactly one result transaction giving the next byte to
// exchange, the chip-select level, busy, and on completion the R1 response (0xFF on
// ready timeout). Application commands are prefixed with CMD55 automatically.
// Throughput is one transaction per clock while the skid stage is empty: the state update
// is a single pass of logic from the input port into the output register, and a one-entry
// skid stage keeps input accepting while a finished result waits on the output side.
// Results are registered on the output side. Config writes are meant for idle periods.
module sd_spi_command_sequencer
  import sdspi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input: tdata = command[7:0], argument[39:8], rx_byte[47:40]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser = operation[1:0]
  input  wire logic [1:0]            in_tuser,
  // Result: tdata = tx_valid[0], tx_byte[8:1], chip_select_low[9], done_res[10],
  //                 response[18:11], busy_res[19], zero pad [23:20]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // Config: index 0 ready_timeout_ms, index 1 response_poll_limit
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_addr,
  input  wire logic [15:0]           cfg_wdata
);

  logic    step;
  result_t core_res;
  result_t buf_res;

  assign step = in_tvalid & in_tready;

  sdspi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .operation (in_tuser),
    .command   (in_tdata[7:0]),
    .argument  (in_tdata[39:8]),
    .rx_byte   (in_tdata[47:40]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .result    (core_res)
  );

  sdspi_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (core_res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_res)
  );

  // pad result to whole bytes
  assign out_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, buf_res};

endmodule
`default_nettype wire

@@ rtl/sdspi_core.sv @@
`default_nettype none
module sdspi_core
  import sdspi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  command,
  input  wire logic [31:0] argument,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output result_t          result
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fbi_r, fbi_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic        prefix_r, prefix_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        sel_r, sel_nxt;
  logic [15:0] tout_cfg_r;
  logic [7:0]  limit_cfg_r;

  logic [6:0]  cur_idx;
  logic [7:0]  poll_dec;

  assign cur_idx  = prefix_r ? IDX_APP : cmd_r[6:0];
  assign poll_dec = poll_r - 8'd1;

  always_comb begin
    logic       do_begin;
    logic [6:0] b_idx;
    logic [31:0] b_arg;
    phase_nxt  = phase_r;
    fbi_nxt    = fbi_r;
    cmd_nxt    = cmd_r;
    arg_nxt    = arg_r;
    prefix_nxt = prefix_r;
    timer_nxt  = timer_r;
    poll_nxt   = poll_r;
    sel_nxt    = sel_r;
    result     = '0;
    do_begin   = 1'b0;
    b_idx      = cmd_r[6:0];
    b_arg      = arg_r;

    case (operation)
      OP_TICK: begin
        if (timer_r != '0) timer_nxt = timer_r - 16'd1;
      end
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          cmd_nxt    = command;
          arg_nxt    = argument;
          prefix_nxt = command[7];
          do_begin   = 1'b1;
          b_idx      = command[7] ? IDX_APP : command[6:0];
          b_arg      = command[7] ? '0 : argument;
        end
      end
      OP_RX: begin
        unique case (phase_r)
          PH_DESEL: begin
            phase_nxt = PH_SEL;
            sel_nxt   = 1'b1;
            result.tx_valid = 1'b1;
            result.tx_byte  = DUMMY_BYTE;
          end
          PH_SEL: begin
            timer_nxt = tout_cfg_r;
            phase_nxt = PH_READY;
            result.tx_valid = 1'b1;
            result.tx_byte  = DUMMY_BYTE;
          end
          PH_READY: begin
            result.tx_valid = 1'b1;
            if (rx_byte == DUMMY_BYTE) begin
              phase_nxt      = PH_FRAME;
              fbi_nxt        = '0;
              result.tx_byte = frame_byte(cur_idx, prefix_r ? '0 : arg_r, 3'd0);
            end else begin
              result.tx_byte = DUMMY_BYTE;
              if (timer_r == '0) begin
                phase_nxt = PH_TOUT;
                sel_nxt   = 1'b0;
              end
            end
          end
          PH_TOUT: begin
            phase_nxt       = PH_IDLE;
            result.done_res = 1'b1;
            result.response = TOUT_RESP;
          end
          PH_FRAME: begin
            result.tx_valid = 1'b1;
            if (fbi_r < FRAME_LAST) begin
              fbi_nxt        = fbi_r + 3'd1;
              result.tx_byte = frame_byte(cur_idx, prefix_r ? '0 : arg_r, fbi_r + 3'd1);
            end else begin
              result.tx_byte = DUMMY_BYTE;
              if (cur_idx == IDX_STOP) begin
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_RESP;
                poll_nxt  = limit_cfg_r;
              end
            end
          end
          PH_SKIP: begin
            phase_nxt = PH_RESP;
            poll_nxt  = limit_cfg_r;
            result.tx_valid = 1'b1;
            result.tx_byte  = DUMMY_BYTE;
          end
          PH_RESP: begin
            if (rx_byte[7]) poll_nxt = poll_dec;
            if (rx_byte[7] && poll_dec != '0) begin
              result.tx_valid = 1'b1;
              result.tx_byte  = DUMMY_BYTE;
            end else if (prefix_r && rx_byte <= APP_RESP_MAX) begin
              // CMD55 accepted: go on with the real command
              prefix_nxt = 1'b0;
              do_begin   = 1'b1;
            end else begin
              prefix_nxt      = 1'b0;
              phase_nxt       = PH_IDLE;
              result.done_res = 1'b1;
              result.response = rx_byte;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase

    if (do_begin) begin
      result.tx_valid = 1'b1;
      if (b_idx != IDX_STOP) begin
        phase_nxt      = PH_DESEL;
        sel_nxt        = 1'b0;
        result.tx_byte = DUMMY_BYTE;
      end else begin
        phase_nxt      = PH_FRAME;
        fbi_nxt        = '0;
        result.tx_byte = frame_byte(b_idx, b_arg, 3'd0);
      end
    end

    result.chip_select_low = sel_nxt;
    result.busy_res        = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fbi_r       <= '0;
      cmd_r       <= '0;
      arg_r       <= '0;
      prefix_r    <= 1'b0;
      timer_r     <= '0;
      poll_r      <= '0;
      sel_r       <= 1'b0;
      tout_cfg_r  <= READY_TIMEOUT_RST;
      limit_cfg_r <= POLL_LIMIT_RST;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        fbi_r    <= fbi_nxt;
        cmd_r    <= cmd_nxt;
        arg_r    <= arg_nxt;
        prefix_r <= prefix_nxt;
        timer_r  <= timer_nxt;
        poll_r   <= poll_nxt;
        sel_r    <= sel_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_READY_TIMEOUT: tout_cfg_r  <= cfg_wdata;
          CFG_POLL_LIMIT:    limit_cfg_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.done_res |-> !result.busy_res)
    else $error("finished result still flagged busy");

  a_tx_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.tx_valid |=> phase_r != PH_IDLE)
    else $error("exchange requested but sequencer went idle");

  a_tout_deselected: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TOUT |-> !sel_r)
    else $error("card still selected after ready timeout");

endmodule
`default_nettype wire

@@ rtl/sdspi_out_buf.sv @@
`default_nettype none
module sdspi_out_buf
  import sdspi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire result_t         push_data,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output result_t              out_data
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    take;

  assign take      = out_v_r & out_ready;
  assign ready     = ~skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_d_nxt = push_data;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage holds data with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("transaction pushed while skid stage full");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_d_r))
    else $error("stalled result changed or dropped");

endmodule
`default_nettype wire
